// ----- design/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
// Each macro samples on the rising clock edge and is switched off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A general implication property.
`define LMFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// A held request keeps its valid high and its payload unchanged in the next cycle.
`define LMFS_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("held request changed");

`endif

// ----- design/lmfs_pkg.sv -----
package lmfs_pkg;

  // Matrix size in use, and the storage size fixed by the field widths.
  localparam int Rows    = 8;
  localparam int Columns = 16;
  localparam int MaxRows = 8;
  localparam int MaxCols = 16;

  localparam int RowW  = 3;
  localparam int ColW  = 4;
  localparam int CmdW  = 3;
  localparam int WordW = 24;

  // Command codes.
  typedef enum logic [CmdW-1:0] {
    CmdSet   = 3'd0,
    CmdClr   = 3'd1,
    CmdFlush = 3'd2,
    CmdClear = 3'd3,
    CmdTick  = 3'd4
  } cmd_e;

  typedef logic [MaxRows-1:0] col_rows_t;
  typedef logic [MaxCols-1:0] row_bits_t;

  // Shift-register pin placement of rows and columns.
  localparam logic [RowW-1:0] RowPin [MaxRows] = '{
    3'd7, 3'd5, 3'd4, 3'd6, 3'd0, 3'd3, 3'd1, 3'd2
  };
  localparam logic [ColW-1:0] ColPin [MaxCols] = '{
    4'd10, 4'd15, 4'd14, 4'd8, 4'd13, 4'd9, 4'd11, 4'd12,
    4'd2,  4'd7,  4'd6,  4'd0, 4'd5,  4'd1, 4'd3,  4'd4
  };

  // Last scan column before the index wraps.
  localparam logic [ColW-1:0] LastCol = ColW'(Columns - 1);

endpackage

// ----- design/lmfs_cmd_if.sv -----
interface lmfs_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [lmfs_pkg::CmdW-1:0] cmd;
  logic [lmfs_pkg::RowW-1:0] row;
  logic [lmfs_pkg::ColW-1:0] col;

  modport source (output valid, cmd, row, col, input ready);
  modport sink   (input valid, cmd, row, col, output ready);
endinterface

// ----- design/lmfs_word_if.sv -----
interface lmfs_word_if;
  logic                       valid;
  logic                       ready;
  logic [lmfs_pkg::WordW-1:0] shift_word;
  logic [lmfs_pkg::ColW-1:0]  scan_column;

  modport source (output valid, shift_word, scan_column, input ready);
  modport sink   (input valid, shift_word, scan_column, output ready);
endinterface

// ----- design/led_matrix_frame_scanner_unit.sv -----
// Column scanner for an 8-row by 16-column multiplexed LED matrix.
// cmd_i takes requests: set pixel, clear pixel, flush, clear drawing frame
// and scan tick. Pixel commands write the drawing frame; flush copies it
// into the shown frame (rows placed through the row pin map) and clears it.
// word_o returns one request per scan tick: the 24-bit shift word (lit rows
// in bits 23..16, one-hot column pin in bits 15..0) and the column index.
// Other commands produce nothing on word_o.
// Every request passes an input register, then combinational logic that
// updates the frames and the scan index and, for a tick, loads the output
// register, where the result waits on word_o until it is taken; one
// request can be taken every cycle while the input register can advance.
// The output register lets non-tick requests keep flowing while a result
// waits. When the receiver holds off, a tick in the input register waits,
// and cmd_i then stalls once that register is full as well.
// Reset clears both frames, the scan index and all valid flags at once.
module led_matrix_frame_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmfs_cmd_if.sink    cmd_i,
  lmfs_word_if.source word_o
);
  import lmfs_pkg::*;

  logic            in_valid_q, in_valid_d;
  logic [CmdW-1:0] in_cmd_q;
  logic [RowW-1:0] in_row_q;
  logic [ColW-1:0] in_col_q;

  row_bits_t draw_q  [MaxRows];
  row_bits_t draw_d  [MaxRows];
  col_rows_t shown_q [MaxCols];
  col_rows_t shown_d [MaxCols];
  col_rows_t flush_rows [MaxCols];
  logic [ColW-1:0] scan_q, scan_d;

  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_word_q;
  logic [ColW-1:0]  out_col_q;

  logic             is_tick, out_free, advance, pix_ok, in_take;
  row_bits_t        col_onehot;

  // Input register handshake.
  assign is_tick  = (in_cmd_q == CmdTick);
  assign out_free = !out_valid_q || word_o.ready;
  assign advance  = in_valid_q && (!is_tick || out_free);
  assign cmd_i.ready = !in_valid_q || advance;
  assign in_take  = cmd_i.valid && cmd_i.ready;
  assign in_valid_d = cmd_i.valid || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= cmd_i.cmd;
      in_row_q <= cmd_i.row;
      in_col_q <= cmd_i.col;
    end
  end

  // Pixels outside the configured matrix are ignored.
  assign pix_ok = ({1'b0, in_row_q} < (RowW+1)'(Rows)) &&
                  ({1'b0, in_col_q} < (ColW+1)'(Columns));

  // Drawing frame turned into pin-mapped column words for a flush.
  always_comb begin
    for (int c = 0; c < MaxCols; c++) begin
      flush_rows[c] = '0;
    end
    for (int c = 0; c < Columns; c++) begin
      for (int r = 0; r < Rows; r++) begin
        flush_rows[c][RowPin[r]] = draw_q[r][c];
      end
    end
  end

  // Frame and scan index update for the request in the input register.
  always_comb begin
    draw_d  = draw_q;
    shown_d = shown_q;
    scan_d  = scan_q;
    if (advance) begin
      case (cmd_e'(in_cmd_q))
        CmdSet: begin
          if (pix_ok) draw_d[in_row_q][in_col_q] = 1'b1;
        end
        CmdClr: begin
          if (pix_ok) draw_d[in_row_q][in_col_q] = 1'b0;
        end
        CmdFlush: begin
          shown_d = flush_rows;
          for (int r = 0; r < MaxRows; r++) draw_d[r] = '0;
        end
        CmdClear: begin
          for (int r = 0; r < MaxRows; r++) draw_d[r] = '0;
        end
        CmdTick: begin
          scan_d = (scan_q == LastCol) ? '0 : scan_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxRows; r++) draw_q[r] <= '0;
      for (int c = 0; c < MaxCols; c++) shown_q[c] <= '0;
      scan_q <= '0;
    end else begin
      draw_q  <= draw_d;
      shown_q <= shown_d;
      scan_q  <= scan_d;
    end
  end

  // Column select bit through the column pin map.
  always_comb begin
    col_onehot = '0;
    col_onehot[ColPin[scan_q]] = 1'b1;
  end

  // Output register.
  assign out_valid_d = (advance && is_tick) || (out_valid_q && !word_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_tick) begin
      out_word_q <= {shown_q[scan_q], col_onehot};
      out_col_q  <= scan_q;
    end
  end

  assign word_o.valid       = out_valid_q;
  assign word_o.shift_word  = out_word_q;
  assign word_o.scan_column = out_col_q;

endmodule

// ----- design/lmfs_checker.sv -----
`include "assert_macros.svh"

module lmfs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [lmfs_pkg::WordW-1:0] shift_word_i,
  input logic [lmfs_pkg::ColW-1:0]  scan_column_i
);
  import lmfs_pkg::*;

  // A held result keeps its payload.
  `LMFS_ASSERT_HOLD(a_word_hold, clk_i, rst_ni, out_valid_i, out_ready_i, shift_word_i)
  `LMFS_ASSERT_HOLD(a_col_hold, clk_i, rst_ni, out_valid_i, out_ready_i, scan_column_i)

  // Exactly one column line is driven per word.
  `LMFS_ASSERT(a_col_onehot, clk_i, rst_ni, out_valid_i |-> $onehot(shift_word_i[15:0]))

  // The scan index stays inside the configured matrix.
  `LMFS_ASSERT(a_col_range, clk_i, rst_ni, out_valid_i |-> ({1'b0, scan_column_i} < (ColW+1)'(Columns)))

endmodule

bind led_matrix_frame_scanner_unit lmfs_checker u_lmfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (word_o.valid),
  .out_ready_i   (word_o.ready),
  .shift_word_i  (word_o.shift_word),
  .scan_column_i (word_o.scan_column)
);
